>>> hw/rtl/cplf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_pkg
// Shared widths and constants of the correlation peak lag finder.
// ----------------------------------------------------------------------------
package cplf_pkg;

  localparam int CFG_W     = 8;
  localparam int COUNT_W   = 10;
  localparam int LAG_IDX_W = 9;
  localparam int LAG_W     = 17;
  localparam int AMP_W     = 32;
  localparam int FRAC_BITS = 8;
  localparam int ROOT_SHIFT = 16;

  localparam logic [CFG_W-1:0] MAX_LAG_RESET = 8'd13;

endpackage

>>> hw/rtl/cplf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_fifo
// Two-entry queue between the sample tracker and the finishing arithmetic.
// ----------------------------------------------------------------------------
module cplf_fifo #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);

endmodule

>>> hw/rtl/cplf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_front
// Takes one sample a cycle when the queue is not full; tracks the best strict
// local maximum and centre sum; queues a window summary on the last sample.
// ----------------------------------------------------------------------------
module cplf_front #(
  parameter int SW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cplf_pkg::CFG_W-1:0]  max_lag,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SW-1:0]               sample,
  input  logic                        q_full,
  output logic                        push,
  output logic [3*SW+SW+10+cplf_pkg::LAG_IDX_W+1+cplf_pkg::CFG_W-1:0] push_data
);

  localparam int SUMW = SW + 10;

  logic [cplf_pkg::COUNT_W-1:0]   count;
  logic signed [SW-1:0]           prev;
  logic signed [SW-1:0]           centre;
  logic signed [SW-1:0]           best;
  logic signed [SW-1:0]           best_l;
  logic signed [SW-1:0]           best_r;
  logic [cplf_pkg::LAG_IDX_W-1:0] best_lag;
  logic signed [SUMW-1:0]         sum;
  logic                           found;

  logic signed [SW-1:0]           s;
  logic                           accept;
  logic                           last;
  logic                           upd;
  logic [cplf_pkg::COUNT_W-1:0]   lag_full;
  logic signed [SW-1:0]           best_next;
  logic signed [SW-1:0]           best_l_next;
  logic signed [SW-1:0]           best_r_next;
  logic [cplf_pkg::LAG_IDX_W-1:0] best_lag_next;
  logic signed [SUMW-1:0]         sum_next;
  logic                           found_next;

  assign s        = $signed(sample);
  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign last     = count >= ({1'b0, max_lag, 1'b0} + cplf_pkg::COUNT_W'(2));
  assign upd      = (count >= cplf_pkg::COUNT_W'(2)) && (centre > prev) && (centre > s)
                    && (centre > best);
  assign lag_full = count - {2'b00, max_lag} - cplf_pkg::COUNT_W'(2);

  always_comb begin
    best_next     = best;
    best_l_next   = best_l;
    best_r_next   = best_r;
    best_lag_next = best_lag;
    found_next    = found;
    sum_next      = sum;
    if (count >= cplf_pkg::COUNT_W'(2)) begin
      sum_next = sum + SUMW'(centre);
    end
    if (upd) begin
      best_next     = centre;
      best_l_next   = prev;
      best_r_next   = s;
      best_lag_next = lag_full[cplf_pkg::LAG_IDX_W-1:0];
      found_next    = 1'b1;
    end
  end

  assign push      = accept & last;
  assign push_data = {max_lag, found_next, sum_next, best_lag_next, best_r_next,
                      best_l_next, best_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      prev     <= '0;
      centre   <= '0;
      best     <= '0;
      best_l   <= '0;
      best_r   <= '0;
      best_lag <= '0;
      sum      <= '0;
      found    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        count    <= '0;
        prev     <= '0;
        centre   <= '0;
        best     <= '0;
        best_l   <= '0;
        best_r   <= '0;
        best_lag <= '0;
        sum      <= '0;
        found    <= 1'b0;
      end else begin
        count    <= count + cplf_pkg::COUNT_W'(1);
        prev     <= centre;
        centre   <= s;
        best     <= best_next;
        best_l   <= best_l_next;
        best_r   <= best_r_next;
        best_lag <= best_lag_next;
        sum      <= sum_next;
        found    <= found_next;
      end
    end
  end

endmodule

>>> hw/rtl/cplf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cplf_sqrt #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] x,
  output logic            busy,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] xs;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;

  assign rem_sh = {rem, xs[2*RW-1 -: 2]};
  assign trial  = (RW + 4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(RW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs <= {xs[2*RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= (RW + 2)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/cplf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cplf_div #(
  parameter int W = 42
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [W:0]   r_sh;

  assign r_sh = {rem, quot[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (r_sh >= {1'b0, dvs}) begin
        rem  <= W'(r_sh - {1'b0, dvs});
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= r_sh[W-1:0];
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/cplf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_back
// Finishes one window: three roots and the mean, then the parabolic fraction
// for a found peak with den > 0, then holds the result word until it is taken.
// ----------------------------------------------------------------------------
module cplf_back #(
  parameter int SW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  output logic                             pop,
  input  logic [3*SW+SW+10+cplf_pkg::LAG_IDX_W+1+cplf_pkg::CFG_W-1:0] q_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cplf_pkg::LAG_W-1:0]       lag_offset,
  output logic [cplf_pkg::AMP_W-1:0]       amplitude,
  output logic                             peak_found
);

  localparam int SUMW = SW + 10;
  localparam int RW   = (SW + 16) / 2;
  localparam int XW   = 2 * RW;
  localparam int DW   = (SUMW > RW + 10) ? SUMW : RW + 10;
  localparam int AW   = (SUMW + 2 > 33) ? SUMW + 2 : 33;
  localparam int O_L   = SW;
  localparam int O_R   = 2 * SW;
  localparam int O_LAG = 3 * SW;
  localparam int O_SUM = O_LAG + cplf_pkg::LAG_IDX_W;
  localparam int O_FND = O_SUM + SUMW;
  localparam int O_MAX = O_FND + 1;
  localparam logic signed [AW-1:0] AMP_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] AMP_MIN = AW'(-64'sd2147483648);

  typedef enum logic [2:0] {IDLE, ROOTS, FRAC, FIN, HOLD} state_t;

  state_t state;

  logic signed [SW-1:0]           v_peak, v_left, v_right;
  logic signed [SUMW-1:0]         v_sum;
  logic [cplf_pkg::CFG_W-1:0]     v_max;
  logic [XW-1:0]                  x_m, x_l, x_r;
  logic [RW-1:0]                  m_root, l_root, r_root;
  logic                           busy_m, busy_l, busy_r;
  logic                           sq_start;
  logic                           dv_start;
  logic [DW-1:0]                  dv_a, dv_b, dv_q, dv_r;
  logic                           dv_busy;

  logic [cplf_pkg::LAG_IDX_W-1:0] k_lag;
  logic                           k_found;
  logic                           k_neg;
  logic                           k_frac_on;
  logic                           k_frac_neg;
  logic signed [SUMW:0]           mean;
  logic [RW-1:0]                  k_m;

  logic signed [RW+1:0]           den;
  logic [RW-1:0]                  diff;
  logic [RW+8:0]                  num;
  logic signed [SUMW:0]           mean_next;
  logic signed [AW-1:0]           amp;
  logic [cplf_pkg::LAG_W-1:0]     frac17;
  logic [cplf_pkg::LAG_W-1:0]     lag_base;

  assign v_peak  = $signed(q_data[SW-1:0]);
  assign v_left  = $signed(q_data[O_L +: SW]);
  assign v_right = $signed(q_data[O_R +: SW]);
  assign v_sum   = $signed(q_data[O_SUM +: SUMW]);
  assign v_max   = q_data[O_MAX +: cplf_pkg::CFG_W];

  function automatic logic [XW-1:0] root_arg(input logic signed [SW-1:0] v);
    logic [XW-1:0] t;
    t = XW'({1'b0, v[SW-2:0]});
    if (v <= 0) t = '0;
    return t << cplf_pkg::ROOT_SHIFT;
  endfunction

  assign x_m = root_arg(v_peak);
  assign x_l = root_arg(v_left);
  assign x_r = root_arg(v_right);

  assign pop      = (state == IDLE) && !q_empty;
  assign sq_start = pop;

  cplf_sqrt #(.RW(RW)) u_sqrt_m (
    .clk(clk), .rst(rst), .start(sq_start), .x(x_m), .busy(busy_m), .root(m_root)
  );
  cplf_sqrt #(.RW(RW)) u_sqrt_l (
    .clk(clk), .rst(rst), .start(sq_start), .x(x_l), .busy(busy_l), .root(l_root)
  );
  cplf_sqrt #(.RW(RW)) u_sqrt_r (
    .clk(clk), .rst(rst), .start(sq_start), .x(x_r), .busy(busy_r), .root(r_root)
  );

  assign den  = $signed({1'b0, m_root, 1'b0}) - $signed({2'b00, l_root})
                - $signed({2'b00, r_root});
  assign diff = (r_root >= l_root) ? (r_root - l_root) : (l_root - r_root);
  assign num  = {1'b0, diff, 8'h00} + (RW + 9)'(den[RW:0]);

  always_comb begin
    dv_start = 1'b0;
    dv_a     = '0;
    dv_b     = '0;
    if (pop) begin
      dv_start = 1'b1;
      dv_a     = DW'(v_sum[SUMW-1] ? -v_sum : v_sum);
      dv_b     = DW'({v_max, 1'b1});
    end else if (state == ROOTS && !busy_m && !busy_l && !busy_r && !dv_busy
                 && k_found && den > 0) begin
      dv_start = 1'b1;
      dv_a     = DW'(num);
      dv_b     = DW'({den[RW:0], 1'b0});
    end
  end

  cplf_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quot(dv_q), .rem(dv_r)
  );

  assign mean_next = k_neg ? -($signed({1'b0, dv_q[SUMW-1:0]}) + (SUMW + 1)'(dv_r != '0))
                           : $signed({1'b0, dv_q[SUMW-1:0]});
  assign amp       = $signed(AW'(k_m)) - AW'(mean);
  assign frac17    = k_frac_on ? dv_q[cplf_pkg::LAG_W-1:0] : '0;
  assign lag_base  = {k_lag, 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (pop) state <= ROOTS;
        end
        ROOTS: begin
          if (!busy_m && !busy_l && !busy_r && !dv_busy) begin
            state <= dv_start ? FRAC : FIN;
          end
        end
        FRAC: begin
          if (!dv_busy) state <= FIN;
        end
        FIN: begin
          state     <= HOLD;
          out_valid <= 1'b1;
        end
        HOLD: begin
          if (out_ready) begin
            state     <= IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      k_lag   <= q_data[O_LAG +: cplf_pkg::LAG_IDX_W];
      k_found <= q_data[O_FND];
      k_neg   <= v_sum[SUMW-1];
    end
    if (state == ROOTS && !busy_m && !busy_l && !busy_r && !dv_busy) begin
      mean       <= mean_next;
      k_m        <= k_found ? m_root : '0;
      k_frac_on  <= dv_start;
      k_frac_neg <= r_root < l_root;
    end
    if (state == FIN) begin
      peak_found <= k_found;
      if (!k_found) lag_offset <= '0;
      else lag_offset <= k_frac_neg ? lag_base - frac17 : lag_base + frac17;
      if (amp > AMP_MAX) amplitude <= AMP_MAX[cplf_pkg::AMP_W-1:0];
      else if (amp < AMP_MIN) amplitude <= AMP_MIN[cplf_pkg::AMP_W-1:0];
      else amplitude <= amp[cplf_pkg::AMP_W-1:0];
    end
  end

endmodule

>>> hw/rtl/correlation_peak_lag_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correlation_peak_lag_finder
// Finds the peak of a correlation window, refines its lag by a parabola
// through the roots of the peak and its neighbours, and gives its amplitude.
//
//   channel | dir | fields (low bit first)
//   s_*     | in  | tdata: corr_sample
//   m_*     | out | tdata: lag_offset, amplitude; tuser: peak_found
//   cfg_*   | in  | max_lag
//
// Samples are taken one a cycle; a window is 2L+3 words.
// After the last word, the roots and the mean divider run in parallel; for a
// found peak with a positive denominator the fraction divider then runs.
// A two-entry queue lets the next windows stream in meanwhile; s_tready
// falls only when it is full. Reset is synchronous and clears all windows.
// ----------------------------------------------------------------------------
module correlation_peak_lag_finder #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cplf_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // corr_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [55:0]                       m_tdata,  // lag_offset, amplitude
  output logic [0:0]                        m_tuser   // peak_found
);

  localparam int SNAP_W = 4 * SAMPLE_WIDTH + 10 + cplf_pkg::LAG_IDX_W + 1 + cplf_pkg::CFG_W;

  logic [cplf_pkg::CFG_W-1:0]  max_lag;
  logic                        push, pop, q_full, q_empty;
  logic [SNAP_W-1:0]           push_data, pop_data;
  logic [cplf_pkg::LAG_W-1:0]  lag_offset;
  logic [cplf_pkg::AMP_W-1:0]  amplitude;
  logic                        peak_found;

  always_ff @(posedge clk) begin
    if (rst) max_lag <= cplf_pkg::MAX_LAG_RESET;
    else if (cfg_we) max_lag <= cfg_wdata;
  end

  cplf_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .max_lag(max_lag), .in_valid(s_tvalid), .in_ready(s_tready),
    .sample(s_tdata[SAMPLE_WIDTH-1:0]), .q_full(q_full), .push(push),
    .push_data(push_data)
  );

  cplf_fifo #(.W(SNAP_W)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .pop_data(pop_data), .full(q_full), .empty(q_empty)
  );

  cplf_back #(.SW(SAMPLE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .pop(pop), .q_data(pop_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .lag_offset(lag_offset),
    .amplitude(amplitude), .peak_found(peak_found)
  );

  assign m_tdata = {7'd0, amplitude, lag_offset};
  assign m_tuser = peak_found;

endmodule

>>> hw/rtl/cplf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplf_checker
// Port-level checks of the correlation peak lag finder.
// ----------------------------------------------------------------------------
module cplf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input stalled after reset");

  a_no_peak: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[16:0] == 17'd0)
    else $error("lag without a peak");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped while stalled");

endmodule

bind correlation_peak_lag_finder cplf_checker u_cplf_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the correlation peak lag finder. Whole lag windows
// are streamed in, directed shapes (extreme samples, negative neighbours, no
// peak, flat parabola, shortest window) and random windows over several
// max_lag settings. A local model predicts every lag/amplitude word, and the
// checker compares the outputs in order. Both stream sides idle at random,
// and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  LIMIT       = 3000000;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  HOLD_CYCLES = 600;

  typedef struct packed {
    logic [cplf_pkg::LAG_W-1:0] lag;
    logic [cplf_pkg::AMP_W-1:0] amp;
    logic                       found;
  } peak_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [cplf_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [55:0]                m_tdata;
  logic [0:0]                 m_tuser;

  correlation_peak_lag_finder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // model state
  longint     lag_half;
  longint     n_taken, prev_s, cent_s, pk, pk_left, pk_right, pk_lag, win_sum;
  bit         pk_seen;
  peak_word_t peak_q[$];

  int   errors, mismatches, words_checked, windows_sent, items_sent, cycles;
  bit   quiet;
  int   hold_req, hold_done, hold_left, rx_pause;
  longint win_q[$];

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint root_q16(input longint v);
    if (v <= 0) return 0;
    return longint'(isqrt(longint'(v) << cplf_pkg::ROOT_SHIFT));
  endfunction

  function automatic void clear_window();
    n_taken = 0; prev_s = 0; cent_s = 0; pk = 0; pk_left = 0; pk_right = 0;
    pk_lag = 0; win_sum = 0; pk_seen = 0;
  endfunction

  function automatic void predict_sample(input logic [31:0] raw);
    longint     s, c, width, mean, m, l, r, den, lagv, amp, num, d, mag, frac;
    peak_word_t w;
    s = longint'(signed'(raw));
    width = 2 * lag_half + 1;
    if (n_taken >= 2) begin
      c = cent_s;
      win_sum += c;
      if (c > prev_s && c > s && c > pk) begin
        pk = c; pk_left = prev_s; pk_right = s;
        pk_lag = n_taken - lag_half - 2;
        pk_seen = 1;
      end
    end
    prev_s = cent_s;
    cent_s = s;
    n_taken++;
    if (n_taken - 1 < 2 * lag_half + 2) return;
    mean = win_sum / width;
    if (win_sum % width != 0 && win_sum < 0) mean -= 1;
    lagv = 0;
    m = 0;
    if (pk_seen) begin
      m = root_q16(pk);
      l = root_q16(pk_left);
      r = root_q16(pk_right);
      den = 2 * m - l - r;
      lagv = pk_lag * 256;
      if (den > 0) begin
        num = (r - l) * 256;
        d = 2 * den;
        mag = num < 0 ? -num : num;
        frac = (mag + d / 2) / d;
        lagv += num < 0 ? -frac : frac;
      end
    end
    amp = m - mean;
    if (amp > 64'sd2147483647) amp = 64'sd2147483647;
    if (amp < -64'sd2147483648) amp = -64'sd2147483648;
    w.lag = lagv[cplf_pkg::LAG_W-1:0];
    w.amp = amp[cplf_pkg::AMP_W-1:0];
    w.found = pk_seen;
    peak_q.push_back(w);
    clear_window();
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_word(input logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    predict_sample(v);
    items_sent++;
  endtask

  task automatic send_window();
    foreach (win_q[i]) send_word(win_q[i][31:0]);
    win_q.delete();
    windows_sent++;
  endtask

  task automatic write_max_lag(input logic [cplf_pkg::CFG_W-1:0] v);
    s_tvalid <= 1'b0;
    wait (peak_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lag_half = v;
  endtask

  // shape: 0 full random, 1 peak over noise, 2 all negative, 3 monotonic
  task automatic build_window(input int shape);
    int  len, pos;
    longint base;
    len = 2 * int'(lag_half) + 3;
    pos = $urandom_range(1, len - 2);
    base = $urandom_range(0, 1) ? longint'($urandom_range(1000, 2000000)) : 64'sd1 << 29;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: win_q.push_back(longint'($urandom()));
        1: win_q.push_back(i == pos ? base + $urandom_range(1, 100000)
                                    : longint'($urandom_range(0, 4000)) - 2000
                                      + ((i == pos - 1 || i == pos + 1) ? base / 2 : 0));
        2: win_q.push_back(-longint'($urandom_range(1, 32'h7fffffff)));
        default: win_q.push_back(longint'(i) * 1000 - 500);
      endcase
    end
  endtask

  task automatic test_directed_shapes();
    write_max_lag(8'd1);
    win_q = '{0, -32'sh80000000, 32'sh7fffffff, -32'sh80000000, 0};
    send_window();
    win_q = '{7, -5000000, 300000, -80, 9};
    send_window();
    win_q = '{1, 2, 3, 4, 5};
    send_window();
    win_q = '{5, 1 << 30, (1 << 30) + 1, 1 << 30, 5};
    send_window();
    win_q = '{-1, -3, -2, -7, -1};
    send_window();
  endtask

  task automatic test_zero_lag();
    write_max_lag(8'd0);
    win_q = '{100, 65536, 200};
    send_window();
    win_q = '{-1, -32'sh80000000, -2};
    send_window();
  endtask

  task automatic test_default_and_widest();
    build_window(1);
    send_window();
    build_window(0);
    send_window();
    write_max_lag(8'd255);
    build_window(1);
    send_window();
  endtask

  task automatic test_random_windows();
    while (items_sent < 850) begin
      write_max_lag(8'($urandom_range(1, 8)));
      quiet = ($urandom_range(3) == 0);
      repeat ($urandom_range(3, 8)) begin
        build_window($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
        send_window();
      end
      quiet = 0;
    end
  endtask

  task automatic test_backpressure();
    write_max_lag(8'd1);
    quiet = 1;
    hold_req++;
    repeat (12) begin
      build_window(1);
      send_window();
    end
    quiet = 0;
  endtask

  always @(posedge clk) begin
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_pause > 0) begin
      rx_pause--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_pause = pick_gap();
    end
  end

  always @(posedge clk) begin
    peak_word_t exp_w, got;
    if (!rst && m_tvalid && m_tready) begin
      got.lag   = m_tdata[cplf_pkg::LAG_W-1:0];
      got.amp   = m_tdata[cplf_pkg::LAG_W+cplf_pkg::AMP_W-1:cplf_pkg::LAG_W];
      got.found = m_tuser[0];
      words_checked++;
      if (peak_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: lag %h amp %h found %b",
                                       got.lag, got.amp, got.found);
      end else begin
        exp_w = peak_q.pop_front();
        if (got !== exp_w) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lag %h amp %h found %b, got lag %h amp %h found %b",
                     exp_w.lag, exp_w.amp, exp_w.found, got.lag, got.amp, got.found);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    lag_half = cplf_pkg::MAX_LAG_RESET;
    clear_window();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_and_widest();
    test_directed_shapes();
    test_zero_lag();
    test_backpressure();
    test_random_windows();
    s_tvalid <= 1'b0;
    wait (peak_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (peak_q.size() != 0) errors++;
    $display("sent %0d samples in %0d windows, checked %0d result words, %0d mismatches",
             items_sent, windows_sent, words_checked, mismatches);
    $display("max_lag settings 0, 1..8, 13 and 255, with a long output hold-off");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
